/* sv/bap_pkg.sv */
// Shared constants, codes and field widths for the buddy allocator.
package bap_pkg;

    localparam int DEF_NUM_UNITS  = 1024;
    localparam int DEF_NUM_ORDERS = 11;

    localparam int OP_W       = 2;
    localparam int REQ_W      = 48;
    localparam int OFF_W      = 48;
    localparam int SIZE_W     = 47;
    localparam int ST_W       = 2;
    localparam int MIN_W      = 6;
    localparam int TOP_W      = 4;
    localparam int CNT_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int MARK_W     = 6;
    localparam int ORD_W      = 4;

    // opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [ST_W-1:0] ST_NO_MEM   = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_OFF  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LOG2 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_ORD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_CNT  = 2'd2;

    localparam logic [MIN_W-1:0] RST_MIN_LOG2 = 6'd12;
    localparam logic [TOP_W-1:0] RST_TOP_ORD  = 4'd10;
    localparam logic [CNT_W-1:0] RST_TOP_CNT  = 11'd1;
    localparam logic [MIN_W-1:0] MIN_LOG2_MAX = 6'd36;

    // unit mark flags: bit 0 allocated, bit 1 on a free list, bits 5:2 order
    localparam logic [1:0] FLG_ALLOC = 2'b01;
    localparam logic [1:0] FLG_FREE  = 2'b10;
    localparam logic [1:0] FLG_NONE  = 2'b00;

endpackage

/* sv/bap_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module bap_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/buddy_allocator.sv */
// Binary buddy allocator: unit marks and free-list links in RAM, list heads in flops.
// An alloc splits the found block down to the wanted order; a free merges free buddies
// upward until a buddy is not free at that order or the top order is reached.
// One word at a time: start is taken only while busy is low; done pulses for one cycle
// with the result, the receiver cannot stall. Reset and a write to any of the three
// registers run a clearing pass over every unit of both RAMs (busy high).
module buddy_allocator #(
    parameter int NUM_UNITS  = bap_pkg::DEF_NUM_UNITS,
    parameter int NUM_ORDERS = bap_pkg::DEF_NUM_ORDERS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [bap_pkg::OP_W-1:0]            opcode,
    input  logic [bap_pkg::REQ_W-1:0]           request_size,
    input  logic [bap_pkg::OFF_W-1:0]           block_offset,
    output logic                                done,
    output logic [bap_pkg::ST_W-1:0]            status,
    output logic [bap_pkg::OFF_W-1:0]           result_offset,
    output logic [bap_pkg::SIZE_W-1:0]          result_size,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bap_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bap_pkg::*;

    // unit index and pointer widths; a pointer with its top bit set is null
    localparam int UW        = $clog2(NUM_UNITS);
    localparam int PW        = UW + 1;
    localparam int HW        = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
    localparam int LOG_FLOOR = $clog2(NUM_UNITS + 1) - 1;
    localparam int MAX_TOP   = (NUM_ORDERS - 1 < LOG_FLOOR) ? NUM_ORDERS - 1 : LOG_FLOOR;
    localparam int TW        = (PW > CNT_W) ? PW : CNT_W;
    localparam int M2W       = MARK_W + PW;
    localparam int SUM_W     = MIN_W + 1;
    localparam logic [PW-1:0]    NIL       = '1;
    localparam logic [ORD_W-1:0] MAX_TOP_O = ORD_W'(MAX_TOP);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_A0   = 4'd2;
    localparam logic [3:0] S_A1   = 4'd3;
    localparam logic [3:0] S_A2   = 4'd4;
    localparam logic [3:0] S_SPL  = 4'd5;
    localparam logic [3:0] S_F0   = 4'd6;
    localparam logic [3:0] S_F1   = 4'd7;
    localparam logic [3:0] S_FM   = 4'd8;
    localparam logic [3:0] S_FM2  = 4'd9;
    localparam logic [3:0] S_FP   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [PW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [MIN_W-1:0]  min_reg, min_next;
    logic [TOP_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [REQ_W-1:0]  req_reg, req_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [REQ_W-1:0]  q_reg, q_next;
    logic              rzero_reg, rzero_next;
    logic [UW-1:0]     u_reg, u_next;
    logic [ORD_W-1:0]  ord_reg, ord_next;
    logic [ORD_W-1:0]  want_reg, want_next;
    logic [ORD_W-1:0]  old_reg, old_next;
    logic [MARK_W-1:0] bm_reg, bm_next;
    logic [PW-1:0]     heads_reg [NUM_ORDERS];
    logic [PW-1:0]     heads_next [NUM_ORDERS];
    logic              done_reg, done_next;
    logic [ST_W-1:0]   status_reg, status_next;
    logic [OFF_W-1:0]  roff_reg, roff_next;
    logic [SIZE_W-1:0] rsize_reg, rsize_next;

    // RAM ports: m1 holds prev links, m2 holds {mark, next link}
    logic          m1_we, m2_we;
    logic [UW-1:0] m1_waddr, m1_raddr, m2_waddr, m2_raddr;
    logic [PW-1:0] m1_wdata, m1_rdata;
    logic [M2W-1:0] m2_wdata, m2_rdata;

    // effective configuration after saturation
    logic [MIN_W-1:0] eff_min;
    logic [ORD_W-1:0] eff_top;
    logic [TW-1:0]    max_cnt, blk_cnt;
    logic [PW-1:0]    eff_units;

    // clearing pass data
    logic [PW-1:0]     clr_step, clr_nxt, clr_prev, clr_link;
    logic              clr_head;
    logic [MARK_W-1:0] clr_mark;

    // allocate search
    logic [ORD_W:0]    bitlen;
    logic [ORD_W-1:0]  want_c, found_o;
    logic              found, too_big;

    bap_ram #(.WIDTH(PW), .DEPTH(NUM_UNITS)) u_link_prev (
        .clk   (clk),
        .we    (m1_we),
        .waddr (m1_waddr),
        .wdata (m1_wdata),
        .raddr (m1_raddr),
        .rdata (m1_rdata)
    );

    bap_ram #(.WIDTH(M2W), .DEPTH(NUM_UNITS)) u_mark_next (
        .clk   (clk),
        .we    (m2_we),
        .waddr (m2_waddr),
        .wdata (m2_wdata),
        .raddr (m2_raddr),
        .rdata (m2_rdata)
    );

    always_comb
    begin
        eff_min = (min_reg > MIN_LOG2_MAX) ? MIN_LOG2_MAX : min_reg;
        eff_top = (top_reg > MAX_TOP_O) ? MAX_TOP_O : top_reg;
        max_cnt = TW'(NUM_UNITS) >> eff_top;
        blk_cnt = (cnt_reg == '0) ? TW'(1) : TW'(cnt_reg);
        if (blk_cnt > max_cnt)
        begin
            blk_cnt = max_cnt;
        end
        eff_units = PW'(blk_cnt << eff_top);
    end

    // reset image: top block heads chained in order, marked free at top order
    always_comb
    begin
        clr_step = PW'(1) << eff_top;
        clr_head = ((clr_cnt_reg & (clr_step - PW'(1))) == '0) && (clr_cnt_reg < eff_units);
        clr_nxt  = clr_cnt_reg + clr_step;
        clr_prev = (clr_head && clr_cnt_reg != '0) ? clr_cnt_reg - clr_step : NIL;
        clr_link = (clr_head && clr_nxt < eff_units) ? clr_nxt : NIL;
        clr_mark = clr_head ? {eff_top, FLG_FREE} : '0;
    end

    // rounded order of the request and first non-empty list at or above it
    always_comb
    begin
        bitlen = '0;
        for (int i = 0; i < 16; i++)
        begin
            if (q_reg[i])
            begin
                bitlen = (ORD_W + 1)'(i + 1);
            end
        end
        want_c  = bitlen[ORD_W-1:0];
        too_big = rzero_reg || ((q_reg >> eff_top) != '0);
        found   = 1'b0;
        found_o = '0;
        for (int o = NUM_ORDERS - 1; o >= 0; o--)
        begin
            if (ORD_W'(o) >= want_c && ORD_W'(o) <= eff_top && !heads_reg[o][UW])
            begin
                found   = 1'b1;
                found_o = ORD_W'(o);
            end
        end
    end

    always_comb
    begin
        logic [ORD_W-1:0]  o_dec;
        logic [ORD_W-1:0]  old_v;
        logic [UW-1:0]     b_v;
        logic [UW-1:0]     u_v;
        logic [PW-1:0]     h_v;
        logic [PW-1:0]     n_v;
        logic [PW-1:0]     p_v;
        logic [MARK_W-1:0] mk_v;
        logic [OFF_W-1:0]  unit_w;
        logic              bad_v;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        min_next     = min_reg;
        top_next     = top_reg;
        cnt_next     = cnt_reg;
        op_next      = op_reg;
        req_next     = req_reg;
        off_next     = off_reg;
        q_next       = q_reg;
        rzero_next   = rzero_reg;
        u_next       = u_reg;
        ord_next     = ord_reg;
        want_next    = want_reg;
        old_next     = old_reg;
        bm_next      = bm_reg;
        heads_next   = heads_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        roff_next    = roff_reg;
        rsize_next   = rsize_reg;
        m1_we        = 1'b0;
        m1_waddr     = '0;
        m1_wdata     = '0;
        m1_raddr     = '0;
        m2_we        = 1'b0;
        m2_waddr     = '0;
        m2_wdata     = '0;
        m2_raddr     = '0;

        o_dec  = ord_reg - ORD_W'(1);
        old_v  = '0;
        b_v    = u_reg ^ (UW'(1) << ord_reg);
        u_v    = u_reg;
        h_v    = heads_reg[ord_reg[HW-1:0]];
        n_v    = m2_rdata[PW-1:0];
        p_v    = m1_rdata;
        mk_v   = m2_rdata[M2W-1:PW];
        unit_w = off_reg >> eff_min;
        bad_v  = ((off_reg & ((OFF_W'(1) << eff_min) - OFF_W'(1))) != '0)
                 || (unit_w >= OFF_W'(eff_units));

        case (state_reg)
            S_CLR:
            begin
                m1_we        = 1'b1;
                m1_waddr     = clr_cnt_reg[UW-1:0];
                m1_wdata     = clr_prev;
                m2_we        = 1'b1;
                m2_waddr     = clr_cnt_reg[UW-1:0];
                m2_wdata     = {clr_mark, clr_link};
                clr_cnt_next = clr_cnt_reg + PW'(1);
                if (clr_cnt_reg == PW'(NUM_UNITS - 1))
                begin
                    for (int i = 0; i < NUM_ORDERS; i++)
                    begin
                        heads_next[i] = NIL;
                    end
                    heads_next[eff_top[HW-1:0]] = '0;
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = opcode;
                    req_next = request_size;
                    off_next = block_offset;
                    case (opcode)
                        OP_ALLOC: state_next = S_A0;
                        OP_FREE,
                        OP_QUERY: state_next = S_F0;
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = ST_BAD_OFF;
                            roff_next   = '0;
                            rsize_next  = '0;
                        end
                    endcase
                end
            end

            S_A0:
            begin
                q_next     = (req_reg - REQ_W'(1)) >> eff_min;
                rzero_next = (req_reg == '0);
                state_next = S_A1;
            end

            S_A1:
            begin
                if (too_big || !found)
                begin
                    done_next   = 1'b1;
                    status_next = too_big ? ST_BAD_SIZE : ST_NO_MEM;
                    roff_next   = '0;
                    rsize_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    u_next     = heads_reg[found_o[HW-1:0]][UW-1:0];
                    m2_raddr   = heads_reg[found_o[HW-1:0]][UW-1:0];
                    ord_next   = found_o;
                    want_next  = want_c;
                    state_next = S_A2;
                end
            end

            S_A2:
            begin
                // unlink the head block; it is allocated at the wanted order
                heads_next[ord_reg[HW-1:0]] = n_v;
                if (!n_v[UW])
                begin
                    m1_we    = 1'b1;
                    m1_waddr = n_v[UW-1:0];
                    m1_wdata = NIL;
                end
                m2_we      = 1'b1;
                m2_waddr   = u_reg;
                m2_wdata   = {want_reg, FLG_ALLOC, NIL};
                state_next = S_SPL;
            end

            S_SPL:
            begin
                if (ord_reg > want_reg)
                begin
                    // upper buddy goes on the list one order down
                    b_v = u_reg ^ (UW'(1) << o_dec);
                    h_v = heads_reg[o_dec[HW-1:0]];
                    m2_we    = 1'b1;
                    m2_waddr = b_v;
                    m2_wdata = {o_dec, FLG_FREE, h_v};
                    if (!h_v[UW])
                    begin
                        m1_we    = 1'b1;
                        m1_waddr = h_v[UW-1:0];
                        m1_wdata = {1'b0, b_v};
                    end
                    heads_next[o_dec[HW-1:0]] = {1'b0, b_v};
                    ord_next = o_dec;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    roff_next   = OFF_W'(u_reg) << eff_min;
                    rsize_next  = SIZE_W'(1) << (SUM_W'(eff_min) + SUM_W'(want_reg));
                    state_next  = S_IDLE;
                end
            end

            S_F0:
            begin
                if (bad_v)
                begin
                    done_next   = 1'b1;
                    status_next = ST_BAD_OFF;
                    roff_next   = '0;
                    rsize_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    u_next     = unit_w[UW-1:0];
                    m2_raddr   = unit_w[UW-1:0];
                    state_next = S_F1;
                end
            end

            S_F1:
            begin
                if (op_reg == OP_QUERY)
                begin
                    done_next   = 1'b1;
                    status_next = ST_OK;
                    roff_next   = '0;
                    rsize_next  = SIZE_W'(1) << (SUM_W'(eff_min) + SUM_W'(mk_v[MARK_W-1:2]));
                    state_next  = S_IDLE;
                end
                else if (!mk_v[0])
                begin
                    done_next   = 1'b1;
                    status_next = ST_BAD_OFF;
                    roff_next   = '0;
                    rsize_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    old_v = (mk_v[MARK_W-1:2] > eff_top) ? eff_top : mk_v[MARK_W-1:2];
                    m2_we    = 1'b1;
                    m2_waddr = u_reg;
                    m2_wdata = {mk_v[MARK_W-1:2], mk_v[1], 1'b0, n_v};
                    old_next = old_v;
                    ord_next = old_v;
                    b_v      = u_reg ^ (UW'(1) << old_v);
                    m1_raddr = b_v;
                    m2_raddr = b_v;
                    state_next = (old_v < eff_top) ? S_FM : S_FP;
                end
            end

            S_FM:
            begin
                if (!mk_v[1] || mk_v[MARK_W-1:2] != ord_reg)
                begin
                    state_next = S_FP;
                end
                else
                begin
                    // buddy is free at this order: unlink it
                    if (!p_v[UW])
                    begin
                        m2_we    = 1'b1;
                        m2_waddr = p_v[UW-1:0];
                        m2_wdata = {ord_reg, FLG_FREE, n_v};
                    end
                    else
                    begin
                        heads_next[ord_reg[HW-1:0]] = n_v;
                    end
                    if (!n_v[UW])
                    begin
                        m1_we    = 1'b1;
                        m1_waddr = n_v[UW-1:0];
                        m1_wdata = p_v;
                    end
                    bm_next    = mk_v;
                    state_next = S_FM2;
                end
            end

            S_FM2:
            begin
                m1_we    = 1'b1;
                m1_waddr = b_v;
                m1_wdata = NIL;
                m2_we    = 1'b1;
                m2_waddr = b_v;
                m2_wdata = {bm_reg[MARK_W-1:2], FLG_NONE[1], bm_reg[0], NIL};
                u_v      = u_reg & ~((UW'(2) << ord_reg) - UW'(1));
                u_next   = u_v;
                ord_next = ord_reg + ORD_W'(1);
                m1_raddr = u_v ^ (UW'(1) << (ord_reg + ORD_W'(1)));
                m2_raddr = u_v ^ (UW'(1) << (ord_reg + ORD_W'(1)));
                state_next = ((ord_reg + ORD_W'(1)) < eff_top) ? S_FM : S_FP;
            end

            S_FP:
            begin
                m2_we    = 1'b1;
                m2_waddr = u_reg;
                m2_wdata = {ord_reg, FLG_FREE, h_v};
                if (!h_v[UW])
                begin
                    m1_we    = 1'b1;
                    m1_waddr = h_v[UW-1:0];
                    m1_wdata = {1'b0, u_reg};
                end
                heads_next[ord_reg[HW-1:0]] = {1'b0, u_reg};
                done_next   = 1'b1;
                status_next = ST_OK;
                roff_next   = '0;
                rsize_next  = SIZE_W'(1) << (SUM_W'(eff_min) + SUM_W'(old_reg));
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // register write: store it and rebuild the whole state
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_LOG2:
                begin
                    min_next     = cfg_data[MIN_W-1:0];
                    state_next   = S_CLR;
                    clr_cnt_next = '0;
                end
                REG_TOP_ORD:
                begin
                    top_next     = cfg_data[TOP_W-1:0];
                    state_next   = S_CLR;
                    clr_cnt_next = '0;
                end
                REG_TOP_CNT:
                begin
                    cnt_next     = cfg_data[CNT_W-1:0];
                    state_next   = S_CLR;
                    clr_cnt_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            min_reg     <= RST_MIN_LOG2;
            top_reg     <= RST_TOP_ORD;
            cnt_reg     <= RST_TOP_CNT;
            done_reg    <= 1'b0;
            for (int i = 0; i < NUM_ORDERS; i++)
            begin
                heads_reg[i] <= NIL;
            end
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            min_reg     <= min_next;
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
            done_reg    <= done_next;
            heads_reg   <= heads_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        req_reg    <= req_next;
        off_reg    <= off_next;
        q_reg      <= q_next;
        rzero_reg  <= rzero_next;
        u_reg      <= u_next;
        ord_reg    <= ord_next;
        want_reg   <= want_next;
        old_reg    <= old_next;
        bm_reg     <= bm_next;
        status_reg <= status_next;
        roff_reg   <= roff_next;
        rsize_reg  <= rsize_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign done          = done_reg;
    assign status        = status_reg;
    assign result_offset = roff_reg;
    assign result_size   = rsize_reg;

    // a failed word carries no offset and no size
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (result_offset == '0 && result_size == '0))
        else $error("failed word carries nonzero offset or size");

    // merging never goes past the top order
    a_merge_ord: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FM) |-> (ord_reg < eff_top))
        else $error("merge order past top order");

    // splitting never goes below the wanted order
    a_split_ord: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SPL) |-> (ord_reg >= want_reg))
        else $error("split order below wanted order");

    // a word is only produced by a finishing state
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) != S_CLR && $past(state_reg) != S_A0
                  && $past(state_reg) != S_A2 && $past(state_reg) != S_FM2))
        else $error("result word from a non-finishing state");

endmodule
